// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/cqfi_pkg.sv =====
// Types, codes and sizes of the circular queue with front insert.
package cqfi_pkg;

	localparam int unsigned DEPTH   = 64;
	localparam int unsigned PTR_W   = $clog2(DEPTH);
	localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
	localparam int unsigned VALUE_W = 16;

	localparam logic [1:0] MODE_APPEND   = 2'd0;
	localparam logic [1:0] MODE_PRIORITY = 2'd1;
	localparam logic [1:0] MODE_REMOVE   = 2'd2;
	localparam logic [1:0] MODE_PEEK     = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [VALUE_W-1:0] item_value;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [1:0]         status;
		logic               queue_empty;
		logic               queue_full;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load_imm;
		logic load_rd;
	} dp_cmd_t;

	typedef struct packed {
		logic read_hit;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/cqfi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cqfi_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cqfi_dp.sv =====
// Datapath: pointers, count, entry RAM and result register.
module cqfi_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cqfi_pkg::item_t   item,
	input  cqfi_pkg::dp_cmd_t cmd,
	output cqfi_pkg::dp_stat_t stat,
	output logic              result_valid,
	input  logic              result_stall,
	output cqfi_pkg::result_t result
);
	import cqfi_pkg::*;

	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;
	item_t              item_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               is_insert;
	logic               is_append;
	logic               is_remove;
	logic               is_full;
	logic               is_empty;
	logic               ins_ok;
	logic               read_hit;
	logic [PTR_W-1:0]   head_prev;
	logic [PTR_W-1:0]   head_next;
	logic [PTR_W-1:0]   tail_next;
	logic [CNT_W-1:0]   count_nxt;
	logic               ram_we;
	logic               ram_re;
	logic [PTR_W-1:0]   ram_waddr;
	logic [VALUE_W-1:0] ram_rdata;
	result_t            imm_res;
	result_t            rd_res;

	assign is_append = (item_q.mode == MODE_APPEND);
	assign is_insert = is_append || (item_q.mode == MODE_PRIORITY);
	assign is_remove = (item_q.mode == MODE_REMOVE);
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign ins_ok    = is_insert && !is_full;
	assign read_hit  = !is_insert && !is_empty;

	assign head_prev = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign head_next = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_next = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (read_hit && is_remove) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign ram_we    = cmd.exec && ins_ok;
	assign ram_re    = cmd.exec && read_hit;
	assign ram_waddr = is_append ? tail_q : head_prev;

	cqfi_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(item_q.item_value),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		imm_res.read_value  = '0;
		imm_res.status      = STATUS_OK;
		if (is_insert && is_full) begin
			imm_res.status = STATUS_FULL;
		end else if (!is_insert && is_empty) begin
			imm_res.status = STATUS_EMPTY;
		end
		imm_res.queue_empty = (count_nxt == '0);
		imm_res.queue_full  = (count_nxt == CNT_W'(DEPTH));
	end

	// pointers and count already moved in the exec cycle
	always_comb begin
		rd_res.read_value  = ram_rdata;
		rd_res.status      = STATUS_OK;
		rd_res.queue_empty = is_empty;
		rd_res.queue_full  = is_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q <= count_nxt;
				if (ins_ok && is_append) begin
					tail_q <= tail_next;
				end else if (ins_ok) begin
					head_q <= head_prev;
				end else if (read_hit && is_remove) begin
					head_q <= head_next;
				end
			end
			if (cmd.load_imm || cmd.load_rd) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.load_imm) begin
			out_q <= imm_res;
		end else if (cmd.load_rd) begin
			out_q <= rd_res;
		end
	end

	assign stat.read_hit = read_hit;
	assign stat.out_free = !out_valid_q || !result_stall;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

endmodule

// ===== rtl/cqfi_ctrl.sv =====
// Controller: sequences capture, execute and RAM read-back per transaction.
module cqfi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  cqfi_pkg::dp_stat_t stat,
	output cqfi_pkg::dp_cmd_t  cmd
);
	import cqfi_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					state_nxt = stat.read_hit ? S_READ : S_IDLE;
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				item_stall  = 1'b0;
				cmd.capture = item_valid;
			end
			S_EXEC: begin
				cmd.exec     = stat.out_free;
				cmd.load_imm = stat.out_free && !stat.read_hit;
			end
			S_READ: begin
				cmd.load_rd = stat.out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/circular_queue_with_front_insert_core.sv =====
// Top level of the circular queue with front insert.
// A 64-entry ring buffer of 16-bit values: append at the tail, insert at the
// head, remove or peek the head; every transaction returns one result with
// the value read, a status and empty/full flags. A front insert steps the
// head pointer back one slot. One transaction is in flight at a time: an
// insert or a refused operation goes through the execute state between accepts,
// a successful remove or peek also through the read state, which covers the
// registered read port of the entry RAM. The result register lets a new
// transaction be accepted while the previous result is still waiting.
`include "assert_macros.svh"

module circular_queue_with_front_insert_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  cqfi_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output cqfi_pkg::result_t result
);
	import cqfi_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cqfi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cqfi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.stat        (stat),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	`ASSERT_IMPLIES(a_flags_excl, clk, arst_n, result_valid, !(result.queue_empty && result.queue_full))
	`ASSERT_IMPLIES(a_empty_refusal, clk, arst_n, result_valid && (result.status == STATUS_EMPTY), (result.read_value == '0) && result.queue_empty)
	`ASSERT_IMPLIES(a_full_refusal, clk, arst_n, result_valid && (result.status == STATUS_FULL), (result.read_value == '0) && result.queue_full)
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, item_valid && !item_stall, item_stall)

endmodule
